// ===== src/agh_pkg.sv =====
// Shared widths, register codes and reset values for the gate and filter chain.
`default_nettype none

package agh_pkg;

	// datapath widths
	localparam int X_W    = 32;  // internal fixed-point sample
	localparam int S_W    = 16;  // PCM sample, gains, alphas
	localparam int A_W    = 34;  // multiplier operand a (signed)
	localparam int B_W    = 17;  // multiplier operand b (signed)
	localparam int PROD_W = A_W + B_W;
	localparam int Q_W    = 16;  // gate factor quotient
	localparam int MAG_W  = 15;  // gate magnitude

	localparam int FRAC_BITS_DEF = 8;
	localparam int GAIN_SHIFT    = 12;
	localparam int COEF_SHIFT    = 16;

	localparam logic [S_W-1:0]   ALPHA_MAX = 16'd65470;
	localparam logic [MAG_W-1:0] MAG_MAX   = 15'h7fff;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SHIFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_IN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_OUT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HP_COEF = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LP_COEF = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GATE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLES = 3'd6;

	localparam logic [3:0]            RST_SHIFT = 4'd11;
	localparam logic signed [S_W-1:0] RST_GAIN  = 16'sd4096;
	localparam logic [S_W-1:0]        RST_HP    = 16'd58982;
	localparam logic [S_W-1:0]        RST_LP    = 16'd38011;
	localparam logic [S_W-1:0]        RST_GATE  = 16'd300;
	localparam logic [2:0]            RST_EN    = 3'd7;

	localparam int EN_GATE = 0;
	localparam int EN_HP   = 1;
	localparam int EN_LP   = 2;

endpackage

`default_nettype wire

// ===== src/agh_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none

module agh_mul (
	input  logic                               clk,
	input  logic signed [agh_pkg::A_W-1:0]     a,
	input  logic signed [agh_pkg::B_W-1:0]     b,
	output logic signed [agh_pkg::PROD_W-1:0]  prod
);
	import agh_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_s1;

endmodule

`default_nettype wire

// ===== src/agh_div.sv =====
// Restoring divider, one quotient bit per cycle, for the soft gate factor.
`default_nettype none

module agh_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [agh_pkg::MAG_W-1:0]  num,
	input  logic [agh_pkg::Q_W-1:0]    den,
	output logic                       busy,
	output logic                       done,
	output logic [agh_pkg::Q_W-1:0]    quot
);
	import agh_pkg::*;

	localparam int CNT_W = $clog2(Q_W);

	logic [Q_W-1:0]   rem_q;
	logic [Q_W-1:0]   quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [Q_W:0]     trial;
	logic [Q_W:0]     diff;
	logic             fits;

	// remainder stays below den, so the doubled value fits one extra bit
	assign trial = {rem_q, 1'b0};
	assign diff  = trial - {1'b0, den};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= Q_W'(num);
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[Q_W-1:0] : trial[Q_W-1:0];
			quot_q <= {quot_q[Q_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

// ===== src/audio_gate_hpf_lpf_chain_top.sv =====
// Noise gate, one-pole high-pass and low-pass chain on a shared multiplier.
// Each sample passes input gain, gate check, optional gate scaling (16-step serial quotient,
// square, multiply), high-pass, low-pass and output gain; a filter switched off is skipped,
// and an output stall holds the result in the finishing state.
// One sample is in flight at a time; the next is taken once the result sits in the output
// register. Reset clears filter state, sequencer, out valid.
`default_nettype none

module audio_gate_hpf_lpf_chain_top #(
	parameter int FRAC_BITS = agh_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [agh_pkg::X_W-1:0]        raw_word,
	input  logic                                  take_start,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [agh_pkg::S_W-1:0]        out_sample,
	input  logic                                  cfg_we,
	input  logic [agh_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [agh_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import agh_pkg::*;

	typedef enum logic [16:0] {
		S_IDLE   = 17'h00001,
		S_GIN    = 17'h00002,
		S_GIN_W  = 17'h00004,
		S_GCHK   = 17'h00008,
		S_GDIV   = 17'h00010,
		S_GSQ    = 17'h00020,
		S_GSQ_W  = 17'h00040,
		S_GMUL   = 17'h00080,
		S_GMUL_W = 17'h00100,
		S_HSUM   = 17'h00200,
		S_HMUL   = 17'h00400,
		S_HMUL_W = 17'h00800,
		S_LMUL   = 17'h01000,
		S_LMUL_W = 17'h02000,
		S_OMUL   = 17'h04000,
		S_OMUL_W = 17'h08000,
		S_DONE   = 17'h10000
	} state_t;

	function automatic logic signed [X_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic all_ones;
		logic all_zeros;
		all_ones  = &v[PROD_W-1:X_W-1];
		all_zeros = ~|v[PROD_W-1:X_W-1];
		if (all_ones || all_zeros)
			return v[X_W-1:0];
		else if (v[PROD_W-1])
			return {1'b1, {(X_W-1){1'b0}}};
		else
			return {1'b0, {(X_W-1){1'b1}}};
	endfunction

	// integer part toward zero, clamped to the PCM range
	function automatic logic signed [S_W-1:0] int16(input logic signed [X_W-1:0] v);
		logic signed [X_W-1:0] t;
		logic all_ones;
		logic all_zeros;
		t = v >>> FRAC_BITS;
		if (v[X_W-1] && (|v[FRAC_BITS-1:0]))
			t = t + 1;
		all_ones  = &t[X_W-1:S_W-1];
		all_zeros = ~|t[X_W-1:S_W-1];
		if (all_ones || all_zeros)
			return t[S_W-1:0];
		else if (t[X_W-1])
			return {1'b1, {(S_W-1){1'b0}}};
		else
			return {1'b0, {(S_W-1){1'b1}}};
	endfunction

	state_t state_q, state_d;

	// configuration
	logic [3:0]            shift_q;
	logic signed [S_W-1:0] gain_in_q;
	logic signed [S_W-1:0] gain_out_q;
	logic [S_W-1:0]        hp_coeff_q;
	logic [S_W-1:0]        lp_coeff_q;
	logic [S_W-1:0]        gate_level_q;
	logic [2:0]            en_q;
	logic [S_W-1:0]        alpha_wr;

	// filter state and working registers
	logic signed [X_W-1:0] hp_q;
	logic signed [X_W-1:0] lp_q;
	logic signed [S_W-1:0] prev_q;
	logic signed [X_W-1:0] x_q;
	logic signed [X_W-1:0] t_q;
	logic [Q_W-1:0]        g2_q;
	logic signed [S_W-1:0] out_sample_q;
	logic                  out_valid_q;

	logic                  accept;
	logic                  out_load;
	logic signed [X_W-1:0] raw_sh;
	logic signed [S_W-1:0] s16;
	logic signed [X_W-1:0] x0;
	logic [X_W:0]          x_abs;
	logic [X_W:0]          mag_full;
	logic [MAG_W-1:0]      gate_mag;
	logic                  gate_on;
	logic signed [S_W-1:0] cur16;
	logic signed [A_W-1:0] hp_sum;
	logic signed [X_W-1:0] prod_g;
	logic signed [X_W-1:0] prod_c;
	logic signed [X_W-1:0] lp_y;

	logic signed [A_W-1:0]    mul_a;
	logic signed [B_W-1:0]    mul_b;
	logic signed [PROD_W-1:0] prod;
	logic                     div_start;
	logic                     div_busy;
	logic                     div_done;
	logic [Q_W-1:0]           div_quot;

	agh_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	agh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (gate_mag),
		.den    (gate_level_q),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign raw_sh = raw_word >>> shift_q;
	assign s16    = raw_sh[S_W-1:0];
	assign x0     = X_W'(s16) <<< FRAC_BITS;

	// gate magnitude: integer part of |x|, saturated
	assign x_abs    = x_q[X_W-1] ? (-{x_q[X_W-1], x_q}) : {x_q[X_W-1], x_q};
	assign mag_full = x_abs >> FRAC_BITS;
	assign gate_mag = (mag_full > (X_W + 1)'(MAG_MAX)) ? MAG_MAX : mag_full[MAG_W-1:0];
	assign gate_on  = en_q[EN_GATE] && (gate_level_q != '0) &&
	                  ({1'b0, gate_mag} < gate_level_q);

	assign cur16  = int16(x_q);
	assign hp_sum = A_W'(hp_q) + A_W'(x_q) - (A_W'(prev_q) <<< FRAC_BITS);
	assign prod_g = sat32(prod >>> GAIN_SHIFT);
	assign prod_c = sat32(prod >>> COEF_SHIFT);
	assign lp_y   = sat32(PROD_W'(lp_q) + (prod >>> COEF_SHIFT));

	assign alpha_wr = (cfg_data > ALPHA_MAX) ? ALPHA_MAX : cfg_data;

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_GIN;
			S_GIN:    state_d = S_GIN_W;
			S_GIN_W:  state_d = S_GCHK;
			S_GCHK: begin
				if (gate_on) begin
					div_start = 1'b1;
					state_d   = S_GDIV;
				end else begin
					state_d = S_HSUM;
				end
			end
			S_GDIV:   if (div_done) state_d = S_GSQ;
			S_GSQ:    state_d = S_GSQ_W;
			S_GSQ_W:  state_d = S_GMUL;
			S_GMUL:   state_d = S_GMUL_W;
			S_GMUL_W: state_d = S_HSUM;
			S_HSUM: begin
				if (en_q[EN_HP])
					state_d = S_HMUL;
				else if (en_q[EN_LP])
					state_d = S_LMUL;
				else
					state_d = S_OMUL;
			end
			S_HMUL:   state_d = S_HMUL_W;
			S_HMUL_W: state_d = en_q[EN_LP] ? S_LMUL : S_OMUL;
			S_LMUL:   state_d = S_LMUL_W;
			S_LMUL_W: state_d = S_OMUL;
			S_OMUL:   state_d = S_OMUL_W;
			S_OMUL_W: state_d = S_DONE;
			S_DONE:   if (out_load) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = A_W'(x_q);
		mul_b = '0;
		case (state_q)
			S_GIN:  mul_b = B_W'(gain_in_q);
			S_GSQ: begin
				mul_a = A_W'(div_quot);
				mul_b = {1'b0, div_quot};
			end
			S_GMUL: mul_b = {1'b0, g2_q};
			S_HMUL: begin
				mul_a = A_W'(t_q);
				mul_b = {1'b0, hp_coeff_q};
			end
			S_LMUL: begin
				mul_a = A_W'(x_q) - A_W'(lp_q);
				mul_b = {1'b0, lp_coeff_q};
			end
			S_OMUL: mul_b = B_W'(gain_out_q);
			default: mul_b = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			hp_q         <= '0;
			lp_q         <= '0;
			prev_q       <= '0;
			shift_q      <= RST_SHIFT;
			gain_in_q    <= RST_GAIN;
			gain_out_q   <= RST_GAIN;
			hp_coeff_q   <= RST_HP;
			lp_coeff_q   <= RST_LP;
			gate_level_q <= RST_GATE;
			en_q         <= RST_EN;
		end else begin
			state_q <= state_d;

			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			// clear filter memory at the start of a take
			if (accept && take_start) begin
				hp_q   <= '0;
				lp_q   <= '0;
				prev_q <= '0;
			end
			if (state_q == S_HSUM)
				prev_q <= cur16;
			if (state_q == S_HMUL_W)
				hp_q <= prod_c;
			if (state_q == S_LMUL_W)
				lp_q <= lp_y;

			if (cfg_we) begin
				case (cfg_index)
					REG_SHIFT:    shift_q      <= cfg_data[3:0];
					REG_GAIN_IN:  gain_in_q    <= cfg_data;
					REG_GAIN_OUT: gain_out_q   <= cfg_data;
					REG_HP_COEF:  hp_coeff_q   <= alpha_wr;
					REG_LP_COEF:  lp_coeff_q   <= alpha_wr;
					REG_GATE:     gate_level_q <= cfg_data;
					REG_ENABLES:  en_q         <= cfg_data[2:0];
					default:      ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE:   if (accept) x_q <= x0;
			S_GIN_W:  x_q <= prod_g;
			S_GSQ_W:  g2_q <= prod[2*Q_W-1:Q_W];
			S_GMUL_W: x_q <= prod_c;
			S_HSUM:   t_q <= sat32(PROD_W'(hp_sum));
			S_HMUL_W: x_q <= prod_c;
			S_LMUL_W: x_q <= lp_y;
			S_OMUL_W: x_q <= prod_g;
			S_DONE:   if (out_load) out_sample_q <= int16(x_q);
			default:  ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

	a_div_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == S_GDIV)
		else $error("divider running outside its wait state");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_GDIV)
		else $error("quotient completed outside its wait state");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == S_GIN)
		else $error("input transaction did not start the sequence");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside the finishing state");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the noise gate, high-pass and low-pass chain.
`default_nettype none

module testbench;
	import agh_pkg::*;

	localparam int                   FRAC     = FRAC_BITS_DEF;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam int                   LIMIT    = 4000;
	localparam int                   DRAIN    = 40;

	typedef struct packed {
		logic signed [X_W-1:0] word;
		logic                  start;
	} mic_item_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic signed [X_W-1:0]        raw_word = '0;
	logic                         take_start = 1'b0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [S_W-1:0]        out_sample;
	logic                         cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index = '0;
	logic [CFG_DATA_W-1:0]        cfg_data = '0;

	mic_item_t             mic_backlog[$];
	logic signed [S_W-1:0] expected_pcm[$];
	mic_item_t             next_item;
	logic                  calm = 1'b0;
	int                    errors = 0;
	int                    quiet = 0;

	// copy of the registers and the filter state
	logic [3:0] m_shift;
	int         m_gain_in, m_gain_out, m_hp_coef, m_lp_coef, m_gate;
	logic [2:0] m_en;
	int         m_hp_mem, m_lp_mem, m_prev;

	audio_gate_hpf_lpf_chain_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.raw_word(raw_word), .take_start(take_start),
		.out_valid(out_valid), .out_stall(out_stall), .out_sample(out_sample),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic int sat16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return int'(v);
	endfunction

	// integer part, truncated toward zero
	function automatic longint whole_part(int x);
		longint v;
		v = x;
		if (v >= 0) return v >>> FRAC;
		return -((-v) >>> FRAC);
	endfunction

	function automatic void chain_reset();
		m_shift    = RST_SHIFT;
		m_gain_in  = RST_GAIN;
		m_gain_out = RST_GAIN;
		m_hp_coef  = RST_HP;
		m_lp_coef  = RST_LP;
		m_gate     = RST_GATE;
		m_en       = RST_EN;
		m_hp_mem   = 0;
		m_lp_mem   = 0;
		m_prev     = 0;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_SHIFT:    m_shift = data[3:0];
			REG_GAIN_IN:  m_gain_in = int'($signed(data));
			REG_GAIN_OUT: m_gain_out = int'($signed(data));
			REG_HP_COEF:  m_hp_coef = (data > ALPHA_MAX) ? ALPHA_MAX : data;
			REG_LP_COEF:  m_lp_coef = (data > ALPHA_MAX) ? ALPHA_MAX : data;
			REG_GATE:     m_gate = data;
			REG_ENABLES:  m_en = data[2:0];
			default: ;
		endcase
	endfunction

	function automatic logic signed [S_W-1:0] chain_predict(logic signed [X_W-1:0] word,
			logic start);
		longint                raw, xv, mag, g, g2, diff;
		logic signed [S_W-1:0] s16;
		int                    x, cur, s;
		if (start) begin
			m_hp_mem = 0;
			m_lp_mem = 0;
			m_prev   = 0;
		end
		raw = word;
		s16 = S_W'(raw >>> m_shift);
		x = sat32(longint'(s16) * (64'sd1 << FRAC));
		x = sat32((longint'(x) * m_gain_in) >>> GAIN_SHIFT);
		if (m_en[EN_GATE] && m_gate != 0) begin
			xv  = x;
			mag = (xv < 0 ? -xv : xv) >>> FRAC;
			if (mag > 32767) mag = 32767;
			if (mag < m_gate) begin
				g  = (mag << 16) / m_gate;
				g2 = (g * g) >>> 16;
				x  = sat32((longint'(x) * g2) >>> COEF_SHIFT);
			end
		end
		cur = sat16(whole_part(x));
		if (m_en[EN_HP]) begin
			s = sat32(longint'(m_hp_mem) + x - longint'(m_prev) * (64'sd1 << FRAC));
			m_hp_mem = sat32((longint'(s) * m_hp_coef) >>> COEF_SHIFT);
			x = m_hp_mem;
		end
		// previous input advances even with the high-pass off
		m_prev = cur;
		if (m_en[EN_LP]) begin
			diff = longint'(x) - m_lp_mem;
			m_lp_mem = sat32(longint'(m_lp_mem) + ((diff * m_lp_coef) >>> COEF_SHIFT));
			x = m_lp_mem;
		end
		x = sat32((longint'(x) * m_gain_out) >>> GAIN_SHIFT);
		return S_W'(sat16(whole_part(x)));
	endfunction

	// sender: predict on each accepted transaction, then present the next item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			raw_word   <= '0;
			take_start <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_pcm.push_back(chain_predict(raw_word, take_start));
			if (!in_valid || !in_stall) begin
				if (mic_backlog.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
					next_item  = mic_backlog.pop_front();
					raw_word   <= next_item.word;
					take_start <= next_item.start;
					in_valid   <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pcm.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %0d",
						$time, out_sample);
					errors++;
				end else if (out_sample !== expected_pcm[0]) begin
					$display("%0t: out_sample mismatch: expected %0d, actual %0d",
						$time, expected_pcm[0], out_sample);
					errors++;
					void'(expected_pcm.pop_front());
				end else begin
					void'(expected_pcm.pop_front());
				end
			end
			out_stall <= !calm && $urandom_range(99) < 7;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	task automatic push_item(input logic signed [X_W-1:0] word, input logic start);
		mic_item_t it;
		it.word  = word;
		it.start = start;
		mic_backlog.push_back(it);
	endtask

	// hold until every queued transaction has produced its result
	task automatic wait_idle();
		do @(negedge clk);
		while (mic_backlog.size() != 0 || in_valid || expected_pcm.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		apply_reg(idx, data);
	endtask

	task automatic program_chain(input logic [15:0] d_shift, input logic [15:0] d_gin,
			input logic [15:0] d_gout, input logic [15:0] d_hp, input logic [15:0] d_lp,
			input logic [15:0] d_gate, input logic [15:0] d_en);
		write_reg(REG_SHIFT, d_shift);
		write_reg(REG_GAIN_IN, d_gin);
		write_reg(REG_GAIN_OUT, d_gout);
		write_reg(REG_HP_COEF, d_hp);
		write_reg(REG_LP_COEF, d_lp);
		write_reg(REG_GATE, d_gate);
		write_reg(REG_ENABLES, d_en);
		write_reg(REG_NONE, 16'($urandom));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(3))
			0: return 16'd4096;
			1: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
			2: return 16'($signed($urandom_range(16384)) - 8192);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_alpha();
		case ($urandom_range(3))
			0: return 16'd0;
			1: return ALPHA_MAX;
			2: return 16'($urandom_range(65535, 65471));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_gate();
		case ($urandom_range(3))
			0: return 16'd0;
			1: return 16'hffff;
			2: return 16'($urandom_range(1023));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_random(input int count);
		logic signed [X_W-1:0] word;
		int                    span, target;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) < 4) begin
				word = $urandom;
			end else begin
				// build a word whose shifted sample lands within a chosen span of zero
				case ($urandom_range(3))
					0: span = 64;
					1: span = 512;
					2: span = 4096;
					default: span = 32767;
				endcase
				target = $signed($urandom_range(2 * span)) - span;
				word = (target <<< m_shift) | ($urandom & ((32'd1 << m_shift) - 1));
			end
			push_item(word, (i == 0 && $urandom_range(1)) || $urandom_range(99) < 3);
		end
	endtask

	initial begin
		logic [15:0] sh;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		chain_reset();

		// defaults: rails, zero, signs and samples either side of the gate
		@(negedge clk);
		push_item(32'sd0, 1'b1);
		push_item(32'sh7fffffff, 1'b0);
		push_item(32'sh80000000, 1'b0);
		push_item(-32'sd1, 1'b0);
		push_item(32'sd1, 1'b0);
		push_item(32'sd204800, 1'b0);
		push_item(-32'sd307200, 1'b0);
		push_item(32'sd612352, 1'b0);
		push_item(32'sd614400, 1'b0);
		push_item(32'sd616448, 1'b0);
		push_item(32'sd67106816, 1'b0);
		push_item(-32'sd67108864, 1'b0);
		push_item(32'sd67106816, 1'b1);
		push_item(-32'sd614400, 1'b0);
		push_item(32'sd0, 1'b0);
		push_item(32'sd2048, 1'b0);
		wait_idle();

		// extreme registers, alpha written above its ceiling
		program_chain(16'hfff0, 16'h7fff, 16'h8000, 16'hffff, 16'd0, 16'hffff, 16'hfff8 | 16'd7);
		@(negedge clk);
		push_item(32'sh7fffffff, 1'b0);
		push_item(32'sh80000000, 1'b0);
		push_item(32'sh00001234, 1'b1);
		push_item(32'shffff8000, 1'b0);
		wait_idle();

		for (int p = 0; p < 12; p++) begin
			case ($urandom_range(2))
				0: sh = 16'd0;
				1: sh = 16'd15;
				default: sh = 16'($urandom_range(15));
			endcase
			sh = {16'($urandom) & 16'hfff0} | sh;
			calm = (p == 5);
			program_chain(sh, pick_gain(), pick_gain(), pick_alpha(), pick_alpha(),
				pick_gate(), 16'($urandom));
			@(negedge clk);
			if (p == 7) begin
				push_random(66);
				wait_idle();
				push_random(66);
			end else begin
				push_random(132);
			end
			wait_idle();
		end
		calm = 1'b0;

		repeat (DRAIN) @(posedge clk);
		if (expected_pcm.size() != 0) begin
			$display("%0t: %0d results never arrived: expected %0d, actual none",
				$time, expected_pcm.size(), expected_pcm[0]);
			errors++;
		end
		if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
